@@ rtl/skn_pkg.sv @@
`default_nettype none

package skn_pkg;

  // Default width that digit runs are padded to
  localparam int PAD_WIDTH_DEF = 10;
  // Length of the 'z' prefix ahead of a leading number
  localparam int PREFIX_LEN = 10;
  // Length of the 'z' fill that replaces an empty key
  localparam int FILL_LEN = 40;

  // Option register bits
  localparam int OPT_PAD = 0;
  localparam int OPT_PREFIX = 1;
  localparam int OPT_FILL = 2;

  localparam logic [6:0] CHAR_Z = 7'h7a;
  localparam logic [6:0] CHAR_0 = 7'h30;
  localparam logic [6:0] CHAR_NONE = 7'h00;

  // Sequencer states: the emitting phases run in this order
  typedef enum logic [2:0] {
    S_IDLE,
    S_PLAN,
    S_PREFIX,
    S_PAD,
    S_DIGITS,
    S_CHARS,
    S_FILL,
    S_TERM
  } state_t;

  // Folded form of one 8-bit code: up to two letters, or one digit
  typedef struct packed {
    logic [1:0] n;
    logic       is_digit;
    logic [6:0] c0;
    logic [6:0] c1;
  } fold_t;

  // Fold the accented upper range (0xC0..0xFF, indexed by the low five bits)
  function automatic fold_t fold_upper(input logic [4:0] idx);
    fold_t r;
    r = '{n: 2'd1, is_digit: 1'b0, c0: 7'("a"), c1: 7'("a")};
    case (idx) inside
      [5'h00:5'h03], 5'h05, 5'h06: r.c0 = 7'("a");
      5'h04: begin
        r.n = 2'd2;
        r.c0 = 7'("a");
        r.c1 = 7'("e");
      end
      5'h07: r.c0 = 7'("c");
      [5'h08:5'h0b]: r.c0 = 7'("e");
      [5'h0c:5'h0f]: r.c0 = 7'("i");
      5'h10: r.c0 = 7'("d");
      5'h11: r.c0 = 7'("n");
      [5'h12:5'h15], 5'h18: r.c0 = 7'("o");
      5'h16: begin
        r.n = 2'd2;
        r.c0 = 7'("o");
        r.c1 = 7'("e");
      end
      5'h17: r.n = 2'd0;
      [5'h19:5'h1b]: r.c0 = 7'("u");
      5'h1c: begin
        r.n = 2'd2;
        r.c0 = 7'("u");
        r.c1 = 7'("e");
      end
      5'h1d: r.c0 = 7'("y");
      5'h1e: r.c0 = 7'("t");
      5'h1f: begin
        r.n = 2'd2;
        r.c0 = 7'("s");
        r.c1 = 7'("s");
      end
      default: r.n = 2'd0;
    endcase
    return r;
  endfunction

  // Fold one Latin-1 / cp1252 code to its key letters
  function automatic fold_t fold_code(input logic [7:0] code);
    fold_t r;
    r = '{n: 2'd1, is_digit: 1'b0, c0: code[6:0], c1: code[6:0]};
    case (code) inside
      [8'h30:8'h39]: r.is_digit = 1'b1;
      [8'h41:8'h5a]: r.c0 = code[6:0] + 7'h20;
      [8'h61:8'h7a]: r.c0 = code[6:0];
      8'h8a, 8'h9a: r.c0 = 7'("s");
      8'h8c, 8'h9c: r.c0 = 7'("o");
      8'h9f, 8'hff: r.c0 = 7'("y");
      [8'hc0:8'hfe]: r = fold_upper(code[4:0]);
      default: r.n = 2'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sort_key_normaliser.sv @@
// Sort key normaliser: takes one character code per request and emits the sort key one
// character per output request. Letters fold to lower-case a-z (a few to two letters),
// digits pass, everything else is dropped; digit runs are held in a PAD_WIDTH-entry
// buffer and flushed with optional zero padding and a ten-'z' prefix, and end_of_string
// closes the key (forty-'z' fill for an empty key, a bare terminator if nothing else).
// A single phase counter drives the output register one character per cycle while the
// output is not stalled by out_ready; each request passes through S_PLAN first, and a
// buffered digit emits no character. in_ready is low while the sequencer works; the
// final character may wait in the output register while the next request is taken.
// Configuration is always ready.
`default_nettype none

module sort_key_normaliser #(
  parameter int PAD_WIDTH = skn_pkg::PAD_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_data,
  // input requests
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [20:0] code_point,
  input  wire logic        end_of_string,
  // output requests
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [6:0]       out_char,
  output logic             char_valid,
  output logic             last
);

  localparam int CW = $clog2(PAD_WIDTH + 1);
  localparam int IDX_W = (PAD_WIDTH > 1) ? $clog2(PAD_WIDTH) : 1;
  localparam int MAX_A = (skn_pkg::FILL_LEN > skn_pkg::PREFIX_LEN) ?
                         skn_pkg::FILL_LEN : skn_pkg::PREFIX_LEN;
  localparam int MAX_LEN = (MAX_A > PAD_WIDTH) ? MAX_A : PAD_WIDTH;
  localparam int LEN_W = $clog2(MAX_LEN + 1);

  skn_pkg::state_t state, state_next;
  logic [LEN_W-1:0] cnt, cnt_next;

  logic [2:0]    option_bits;
  logic [3:0]    digit_buffer [PAD_WIDTH];
  logic [CW-1:0] digit_count;
  logic          long_run;
  logic          anything_emitted;

  // Plan of the current request
  logic          eos_r;
  logic          pfx_r;
  logic [CW-1:0] pad_n;
  logic [CW-1:0] dig_n;
  logic [1:0]    n_chr;
  logic          fill_r;
  logic          term_r;
  logic [6:0]    c0_r, c1_r;

  // Accept-time decode
  skn_pkg::fold_t fd;
  logic           cp_ok;
  logic [1:0]     k;
  logic           is_dig;
  logic           buffering;
  logic           has_run;
  logic           in_acc;

  assign cfg_ready = 1'b1;
  assign in_ready = (state == skn_pkg::S_IDLE);
  assign in_acc = in_valid && in_ready;

  always_comb begin
    fd = skn_pkg::fold_code(code_point[7:0]);
    cp_ok = (code_point[20:8] == '0);
    k = cp_ok ? fd.n : 2'd0;
    is_dig = cp_ok && fd.is_digit && !end_of_string;
    buffering = is_dig && !long_run && (digit_count < CW'(PAD_WIDTH));
    has_run = (digit_count != '0);
  end

  // Hold the option register
  always_ff @(posedge clk) begin
    if (rst) begin
      option_bits <= '0;
    end else if (cfg_valid && cfg_ready) begin
      option_bits <= cfg_data;
    end
  end

  // Store buffered digits
  always_ff @(posedge clk) begin
    if (in_acc && buffering) begin
      digit_buffer[digit_count[IDX_W-1:0]] <= code_point[3:0];
    end
  end

  // Update run state and the emitted flag on each request
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= '0;
      long_run <= 1'b0;
      anything_emitted <= 1'b0;
    end else if (in_acc) begin
      if (end_of_string) begin
        digit_count <= '0;
        long_run <= 1'b0;
        anything_emitted <= 1'b0;
      end else if (buffering) begin
        digit_count <= digit_count + 1'b1;
      end else begin
        digit_count <= '0;
        long_run <= is_dig;
        anything_emitted <= anything_emitted || has_run || (k != 2'd0);
      end
    end
  end

  // Latch the plan of a request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      eos_r <= end_of_string;
      pfx_r <= !buffering && has_run && !anything_emitted &&
               option_bits[skn_pkg::OPT_PREFIX];
      pad_n <= (!buffering && has_run && option_bits[skn_pkg::OPT_PAD]) ?
               CW'(PAD_WIDTH) - digit_count : '0;
      dig_n <= buffering ? '0 : digit_count;
      n_chr <= (end_of_string || buffering) ? 2'd0 : k;
      fill_r <= end_of_string && !has_run && !anything_emitted &&
                option_bits[skn_pkg::OPT_FILL];
      term_r <= end_of_string && !has_run &&
                !(!anything_emitted && option_bits[skn_pkg::OPT_FILL]);
      c0_r <= fd.c0;
      c1_r <= fd.c1;
    end
  end

  // Phase decode
  logic             emitting;
  logic             fire;
  logic [LEN_W-1:0] ph_len;
  logic             ph_last;
  logic [6:0]       ph_char;
  logic [5:0]       nonempty, above, cand;
  skn_pkg::state_t  follow;
  logic             last_bit;

  always_comb begin
    emitting = (state != skn_pkg::S_IDLE) && (state != skn_pkg::S_PLAN);
    fire = emitting && (!out_valid || out_ready);
    nonempty = {term_r, fill_r, n_chr != 2'd0, dig_n != '0, pad_n != '0, pfx_r};
    ph_len = '0;
    ph_char = skn_pkg::CHAR_NONE;
    above = 6'b000000;
    case (state)
      skn_pkg::S_PLAN: above = 6'b111111;
      skn_pkg::S_PREFIX: begin
        above = 6'b111110;
        ph_len = LEN_W'(skn_pkg::PREFIX_LEN);
        ph_char = skn_pkg::CHAR_Z;
      end
      skn_pkg::S_PAD: begin
        above = 6'b111100;
        ph_len = LEN_W'(pad_n);
        ph_char = skn_pkg::CHAR_0;
      end
      skn_pkg::S_DIGITS: begin
        above = 6'b111000;
        ph_len = LEN_W'(dig_n);
        ph_char = skn_pkg::CHAR_0 + 7'(digit_buffer[cnt[IDX_W-1:0]]);
      end
      skn_pkg::S_CHARS: begin
        above = 6'b110000;
        ph_len = LEN_W'(n_chr);
        ph_char = (cnt == '0) ? c0_r : c1_r;
      end
      skn_pkg::S_FILL: begin
        above = 6'b100000;
        ph_len = LEN_W'(skn_pkg::FILL_LEN);
        ph_char = skn_pkg::CHAR_Z;
      end
      skn_pkg::S_TERM: begin
        ph_len = LEN_W'(1);
        ph_char = skn_pkg::CHAR_NONE;
      end
      default: above = 6'b000000;
    endcase
    cand = nonempty & above;
    if (cand[0]) follow = skn_pkg::S_PREFIX;
    else if (cand[1]) follow = skn_pkg::S_PAD;
    else if (cand[2]) follow = skn_pkg::S_DIGITS;
    else if (cand[3]) follow = skn_pkg::S_CHARS;
    else if (cand[4]) follow = skn_pkg::S_FILL;
    else if (cand[5]) follow = skn_pkg::S_TERM;
    else follow = skn_pkg::S_IDLE;
    ph_last = (cnt == ph_len - 1'b1);
    last_bit = eos_r && ph_last && (follow == skn_pkg::S_IDLE);
  end

  // Sequencer: advance through the phases, one character per cycle unless out_ready stalls
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    case (state)
      skn_pkg::S_IDLE: begin
        if (in_acc) begin
          state_next = skn_pkg::S_PLAN;
          cnt_next = '0;
        end
      end
      skn_pkg::S_PLAN: begin
        state_next = follow;
        cnt_next = '0;
      end
      default: begin
        if (fire) begin
          if (ph_last) begin
            state_next = follow;
            cnt_next = '0;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skn_pkg::S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_char <= ph_char;
      char_valid <= (state != skn_pkg::S_TERM);
      last <= last_bit;
    end
  end

  // Checks
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({out_char, char_valid, last}))
    else $error("result changed while stalled");

  assert property (@(posedge clk) disable iff (rst) digit_count <= CW'(PAD_WIDTH))
    else $error("digit buffer overfilled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !char_valid |-> last && (out_char == skn_pkg::CHAR_NONE))
    else $error("bare terminator malformed");

  assert property (@(posedge clk) disable iff (rst) long_run |-> digit_count == '0)
    else $error("digits buffered during a pass-through run");

endmodule

`default_nettype wire
